// ----- src/fib_pkg.sv -----
// ----------------------------------------------------------------------------
// fib_pkg: shared constants and types for the Fibonacci matrix power block
// Holds the modulus, field widths and the reduction helper types.
// ----------------------------------------------------------------------------
package fib_pkg;

	localparam int unsigned POS_W    = 32;
	localparam int unsigned RES_W    = 30;
	localparam int unsigned DEG_BITS_DEF = 32;
	localparam logic [RES_W-1:0] FIB_MOD = 30'd1000000009;
	// sum of two 60-bit products stays below 2^61
	localparam int unsigned ACC_W    = 61;
	localparam int unsigned PROD_W   = 60;

	// multiplier unit request
	typedef struct packed {
		logic             start;
		logic [RES_W-1:0] a;
		logic [RES_W-1:0] b;
		logic [RES_W-1:0] c;
		logic [RES_W-1:0] d;
	} dot_req_t;

	typedef struct packed {
		logic             done;
		logic [RES_W-1:0] res;
	} dot_rsp_t;

endpackage

// ----- src/fibonacci_mod_prime_matrix_power.sv -----
// Fibonacci by 2x2 matrix power modulo 1000000009. Each item carries start,
// end and shift; the exponent e = end - start - shift gives F(e+1), or zero
// when e is negative. One item is worked at a time: the square-and-multiply
// sequencer drives a single shared modular dot-product unit. One matrix entry
// goes through issue, two products, folds of the upper bits, a final compare
// and subtract, and handoff; a matrix step is four entries, one square per
// exponent bit and one more multiply per set bit. A negative exponent skips
// the sequencer and goes straight to the output stage. The input is not ready
// while an item is worked or while its result waits for a full output
// register; a result held in the output register does not block the next item.
// ----------------------------------------------------------------------------
// fibonacci_mod_prime_matrix_power: top level
// Stream wrapper around the exponent sequencer and shared dot-product unit.
// ----------------------------------------------------------------------------
module fibonacci_mod_prime_matrix_power
	import fib_pkg::*;
#(
	parameter int unsigned DEG_BITS = DEG_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // start_pos[31:0], end_pos[63:32], shift[95:64]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata   // ways_mod[29:0], zero pad [31:30]
);

	typedef enum logic [1:0] { ST_IDLE, ST_RUN, ST_PUT } st_t;

	st_t              st_q;
	logic             neg_q;
	logic             out_vld_q;
	logic [RES_W-1:0] res_q;
	logic             slot_free;
	logic [POS_W+1:0] e_full;
	logic             e_neg;
	logic             seq_go;
	logic             seq_busy, seq_done;
	logic [RES_W-1:0] seq_tl;
	dot_req_t         req;
	dot_rsp_t         rsp;

	// exact signed difference in 34 bits
	assign e_full = {2'b00, s_tdata[63:32]} - {2'b00, s_tdata[31:0]}
	              - {2'b00, s_tdata[95:64]};
	assign e_neg  = e_full[POS_W+1];
	assign s_tready = (st_q == ST_IDLE);
	assign seq_go   = s_tvalid && s_tready && !e_neg;
	assign slot_free = !out_vld_q || m_tready;

	fib_seq #(.DEG_BITS(DEG_BITS)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (seq_go),
		.exp_bits (DEG_BITS'(e_full)),
		.busy     (seq_busy),
		.done     (seq_done),
		.top_left (seq_tl),
		.req      (req),
		.rsp      (rsp)
	);

	fib_dot u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// accept, run, then hand the result to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			neg_q     <= 1'b0;
			out_vld_q <= 1'b0;
			res_q     <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						neg_q <= e_neg;
						if (e_neg) st_q <= ST_PUT;
						else st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (seq_done) st_q <= ST_PUT;
				end
				ST_PUT: if (slot_free) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase

			// load the output register once it is free, drop it when taken
			if (st_q == ST_PUT && slot_free) begin
				res_q     <= neg_q ? '0 : seq_tl;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, res_q};

	ap_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN && !seq_done) |-> seq_busy)
		else $error("sequencer idle during run");
	ap_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_q < FIB_MOD)
		else $error("output out of range");
	ap_seq_idle: assert property (@(posedge clk) disable iff (!arst_n)
		seq_done |-> st_q == ST_RUN)
		else $error("unexpected sequencer finish");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("output item changed while waiting");

endmodule

// ----- src/fib_dot.sv -----
// ----------------------------------------------------------------------------
// fib_dot: modular dot product unit
// Computes (a*b + c*d) mod FIB_MOD on one shared 31x30 multiplier: two
// products, then fold the bits above 2^30 back in as hi * (2^30 mod FIB_MOD)
// until the value fits 30 bits, and finish with one compare and subtract.
// ----------------------------------------------------------------------------
module fib_dot
	import fib_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  dot_req_t req,
	output dot_rsp_t rsp
);

	typedef enum logic [1:0] {
		ST_IDLE, ST_P1, ST_FOLD, ST_DONE
	} st_t;

	localparam int unsigned HI_W = ACC_W - RES_W;
	// 2^30 mod FIB_MOD: weight of the bits above the low 30
	localparam logic [RES_W-1:0] FOLD_C = 30'd73741815;

	st_t              st_q;
	logic [RES_W-1:0] c_q, d_q;
	logic [ACC_W-1:0] rem_q;
	logic [HI_W-1:0]  mul_x;
	logic [RES_W-1:0] mul_y;
	logic [ACC_W-1:0] mul_out;
	logic [HI_W-1:0]  rem_hi;
	logic [ACC_W-1:0] rem_lo;

	assign rem_hi = rem_q[ACC_W-1:RES_W];
	assign rem_lo = {{HI_W{1'b0}}, rem_q[RES_W-1:0]};

	// one multiplier, shared between both products and every fold
	always_comb begin
		case (st_q)
			ST_IDLE: begin
				mul_x = HI_W'(req.a);
				mul_y = req.b;
			end
			ST_P1: begin
				mul_x = HI_W'(c_q);
				mul_y = d_q;
			end
			default: begin
				mul_x = rem_hi;
				mul_y = FOLD_C;
			end
		endcase
	end

	assign mul_out = {{RES_W{1'b0}}, mul_x} * {{HI_W{1'b0}}, mul_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			c_q   <= '0;
			d_q   <= '0;
			rem_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (req.start) begin
						rem_q <= mul_out;
						c_q   <= req.c;
						d_q   <= req.d;
						st_q  <= ST_P1;
					end
				end
				ST_P1: begin
					rem_q <= rem_q + mul_out;
					st_q  <= ST_FOLD;
				end
				ST_FOLD: begin
					// fold the upper bits until the value fits 30 bits
					if (rem_hi != '0) begin
						rem_q <= mul_out + rem_lo;
					end else begin
						if (rem_q[RES_W-1:0] >= FIB_MOD) rem_q <= rem_lo - ACC_W'(FIB_MOD);
						st_q <= ST_DONE;
					end
				end
				ST_DONE: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.done = (st_q == ST_DONE);
	assign rsp.res  = rem_q[RES_W-1:0];

	ap_res_lt_mod: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> rem_q < ACC_W'(FIB_MOD))
		else $error("reduced value not below modulus");
	ap_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("done held longer than one cycle");
	ap_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.start && st_q == ST_IDLE) |=> st_q == ST_P1)
		else $error("start not taken");

endmodule

// ----- src/fib_seq.sv -----
// ----------------------------------------------------------------------------
// fib_seq: square-and-multiply sequencer
// Walks the exponent bits from the top, issuing the dot products of each
// matrix square and multiply to the shared unit one entry at a time.
// ----------------------------------------------------------------------------
module fib_seq
	import fib_pkg::*;
#(
	parameter int unsigned DEG_BITS = DEG_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [DEG_BITS-1:0] exp_bits,
	output logic                busy,
	output logic                done,
	output logic [RES_W-1:0]    top_left,
	output dot_req_t            req,
	input  dot_rsp_t            rsp
);

	localparam int unsigned BIT_W = (DEG_BITS > 1) ? $clog2(DEG_BITS) : 1;

	typedef enum logic [1:0] { ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE } st_t;

	st_t                 st_q;
	logic [RES_W-1:0]    m_q [4];
	logic [RES_W-1:0]    n_q [4];
	logic [DEG_BITS-1:0] e_q;
	logic [BIT_W-1:0]    bit_q;
	logic [1:0]          ent_q;
	logic                mul_q;  // 0: square, 1: times base
	logic [RES_W-1:0]    y0, y1, y2, y3;

	// second operand: acc itself when squaring, else [[1,1],[1,0]]
	always_comb begin
		if (mul_q) begin
			y0 = RES_W'(1); y1 = RES_W'(1); y2 = RES_W'(1); y3 = '0;
		end else begin
			y0 = m_q[0]; y1 = m_q[1]; y2 = m_q[2]; y3 = m_q[3];
		end
	end

	// entry r = x[row][0]*y[0][col] + x[row][1]*y[1][col]
	always_comb begin
		req.start = (st_q == ST_ISSUE);
		req.a = ent_q[1] ? m_q[2] : m_q[0];
		req.c = ent_q[1] ? m_q[3] : m_q[1];
		req.b = ent_q[0] ? y1 : y0;
		req.d = ent_q[0] ? y3 : y2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			ent_q <= '0;
			mul_q <= 1'b0;
			bit_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (go) begin
						m_q[0] <= RES_W'(1); m_q[1] <= '0;
						m_q[2] <= '0;        m_q[3] <= RES_W'(1);
						e_q    <= exp_bits;
						bit_q  <= BIT_W'(DEG_BITS - 1);
						ent_q  <= '0;
						mul_q  <= 1'b0;
						st_q   <= ST_ISSUE;
					end
				end
				ST_ISSUE: st_q <= ST_WAIT;
				ST_WAIT: begin
					if (rsp.done) begin
						n_q[ent_q] <= rsp.res;
						if (ent_q != 2'd3) begin
							ent_q <= ent_q + 1'b1;
							st_q  <= ST_ISSUE;
						end else begin
							// commit the finished matrix
							m_q[0] <= n_q[0]; m_q[1] <= n_q[1];
							m_q[2] <= n_q[2]; m_q[3] <= rsp.res;
							ent_q  <= '0;
							if (!mul_q && e_q[bit_q]) begin
								mul_q <= 1'b1;
								st_q  <= ST_ISSUE;
							end else if (bit_q == '0) begin
								st_q <= ST_DONE;
							end else begin
								mul_q <= 1'b0;
								bit_q <= bit_q - 1'b1;
								st_q  <= ST_ISSUE;
							end
						end
					end
				end
				ST_DONE: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign busy     = (st_q != ST_IDLE);
	assign done     = (st_q == ST_DONE);
	assign top_left = m_q[0];

	ap_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(go && !busy) |=> st_q == ST_ISSUE)
		else $error("go not taken");
	ap_issue_wait: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> st_q == ST_WAIT)
		else $error("issue not followed by wait");
	ap_tl_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> top_left < FIB_MOD)
		else $error("result out of range");

endmodule
